/* sv/hrd_pkg.sv */
package hrd_pkg;

  localparam int TEMP_W     = 24;
  localparam int COEFF_W    = 16;
  localparam int LEN_W      = 5;
  localparam int IDX_W      = 4;
  localparam int OP_W       = 2;
  localparam int MAX_EMIT   = 16;
  localparam int LAP_W      = 27;
  localparam int PROD_W     = 44;
  localparam int SUM_W      = 30;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int TDATA_W    = 32;
  localparam int TDATA_PAD  = TDATA_W - IDX_W - TEMP_W;

  localparam logic [COEFF_W-1:0] COEFF_RST = 16'd6554;
  localparam logic [LEN_W-1:0]   LEN_RST   = 5'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_COEFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 1'b1;

  localparam logic signed [SUM_W-1:0] TEMP_MAX = 30'sd8388607;
  localparam logic signed [SUM_W-1:0] TEMP_MIN = -30'sd8388608;
  localparam logic signed [PROD_W:0]  ROUND_HALF = 45'sd32768;

  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef enum logic [OP_W-1:0] {
    OP_FILL = 2'd0,
    OP_SET  = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_TICK = 1'b1
  } state_e;

  // one cell handed to the stencil datapath
  typedef struct packed {
    temp_t left;
    temp_t t;
    temp_t right;
    logic  last;
    logic  cell0;
  } sten_in_t;

  // one finished cell
  typedef struct packed {
    temp_t temp;
    logic  last;
    logic  sat;
  } sten_out_t;

endpackage

/* sv/hrd_cell_mem.sv */
module hrd_cell_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fill_en_i,
  input  hrd_pkg::temp_t fill_val_i,
  input  logic           wr_en_i,
  input  logic [AW-1:0]  wr_addr_i,
  input  hrd_pkg::temp_t wr_data_i,
  input  logic           rd_en_i,
  input  logic [AW-1:0]  rd_addr_i,
  output hrd_pkg::temp_t rd_data_o
);
  import hrd_pkg::*;

  temp_t            mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  temp_t            fill_q;
  temp_t            word_q;
  logic             hit_q;

  // a cell not written since the last fill reads as the fill value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
    end else if (fill_en_i) begin
      valid_q <= '0;
      fill_q  <= fill_val_i;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      word_q <= mem[rd_addr_i];
      hit_q  <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = hit_q ? word_q : fill_q;

endmodule

/* sv/hrd_stencil.sv */
module hrd_stencil #(
  parameter int IW = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_vld_i,
  input  hrd_pkg::sten_in_t                 in_i,
  input  logic [IW-1:0]                     in_idx_i,
  input  logic [hrd_pkg::COEFF_W-1:0]       coeff_i,
  output logic                              out_vld_o,
  output hrd_pkg::sten_out_t                out_o,
  output logic [IW-1:0]                     out_idx_o,
  output logic                              wb_en_o,
  output logic [IW-1:0]                     wb_idx_o,
  output hrd_pkg::temp_t                    wb_data_o
);
  import hrd_pkg::*;

  logic signed [LAP_W-1:0]  lap;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] m_prod_q;
  temp_t                    m_t_q;
  logic                     m_last_q;
  logic                     m_cell0_q;
  logic [IW-1:0]            m_idx_q;
  logic                     m_vld_q;

  logic signed [PROD_W:0]   rnd;
  logic signed [SUM_W-1:0]  sum;
  temp_t                    new_temp;
  logic                     new_sat;

  sten_out_t                o_q;
  logic [IW-1:0]            o_idx_q;
  logic                     o_vld_q;

  // multiply stage: left - 2t + right, times the coefficient
  assign lap = $signed({{3{in_i.left[TEMP_W-1]}}, in_i.left})
             - $signed({{2{in_i.t[TEMP_W-1]}}, in_i.t, 1'b0})
             + $signed({{3{in_i.right[TEMP_W-1]}}, in_i.right});
  assign prod_d = $signed({{(PROD_W-COEFF_W){1'b0}}, coeff_i})
                * $signed({{(PROD_W-LAP_W){lap[LAP_W-1]}}, lap});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      m_vld_q <= in_vld_i;
      o_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && in_vld_i) begin
      m_prod_q  <= prod_d;
      m_t_q     <= in_i.t;
      m_last_q  <= in_i.last;
      m_cell0_q <= in_i.cell0;
      m_idx_q   <= in_idx_i;
    end
  end

  // round half up, floor shift, add to the old value and clip
  always_comb begin
    rnd      = $signed({m_prod_q[PROD_W-1], m_prod_q}) + ROUND_HALF;
    sum      = $signed({{(SUM_W-TEMP_W){m_t_q[TEMP_W-1]}}, m_t_q})
             + $signed({rnd[PROD_W], rnd[PROD_W:16]});
    new_sat  = 1'b0;
    new_temp = m_t_q;
    if (!m_cell0_q) begin
      if (sum > TEMP_MAX) begin
        new_temp = TEMP_MAX[TEMP_W-1:0];
        new_sat  = 1'b1;
      end else if (sum < TEMP_MIN) begin
        new_temp = TEMP_MIN[TEMP_W-1:0];
        new_sat  = 1'b1;
      end else begin
        new_temp = sum[TEMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && m_vld_q) begin
      o_q.temp <= new_temp;
      o_q.last <= m_last_q;
      o_q.sat  <= new_sat;
      o_idx_q  <= m_idx_q;
    end
  end

  assign wb_en_o   = en_i && m_vld_q;
  assign wb_idx_o  = m_idx_q;
  assign wb_data_o = new_temp;
  assign out_vld_o = o_vld_q;
  assign out_o     = o_q;
  assign out_idx_o = o_idx_q;

endmodule

/* sv/heat_rod_diffusion_step_top.sv */
// Explicit finite-difference step of the 1-D heat equation on a rod of up to
// MAX_CELLS Q15.8 cells held in one synchronous cell memory. Input opcode 0
// fills every cell with one value and opcode 1 sets one cell (ignored at or
// beyond the rod length); neither gives a result. Opcode 2 runs a tick: the
// cells are swept out of the memory one a cycle while the output is not
// stalled, each new value t + K*(left - 2t + right) is rounded, clipped,
// written back and sent as one result item, cell 0 unchanged, with tlast on
// the final cell. The single read port of the cell memory sets that pace,
// and output stalls hold the whole sweep. No new item is taken while a tick
// is in progress. Fill clears a valid bit per cell and keeps the fill value
// in a register, so no clearing pass is needed after reset or fill.
module heat_rod_diffusion_step_top #(
  parameter int MAX_CELLS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // cell_index [3:0], value [27:4], zero pad
  input  logic [hrd_pkg::TDATA_W-1:0]     s_axis_tdata,
  // opcode [1:0]
  input  logic [hrd_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cell_index_res [3:0], temperature [27:4], zero pad
  output logic [hrd_pkg::TDATA_W-1:0]     m_axis_tdata,
  output logic                            m_axis_tlast,
  // saturated [0]
  output logic [0:0]                      m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [hrd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hrd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import hrd_pkg::*;

  localparam int AW   = $clog2(MAX_CELLS);
  localparam int EMIT = (MAX_CELLS < MAX_EMIT) ? MAX_CELLS : MAX_EMIT;
  // counters hold the rod length itself and the 4-bit output index
  localparam int CW   = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

  // configuration registers
  logic [COEFF_W-1:0] coeff_q, coeff_d;
  logic [LEN_W-1:0]   len_q, len_d;

  always_comb begin
    coeff_d = coeff_q;
    len_d   = len_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COEFF: coeff_d = cfg_data_i;
        CFG_LEN:   len_d   = cfg_data_i[LEN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= COEFF_RST;
      len_q   <= LEN_RST;
    end else begin
      coeff_q <= coeff_d;
      len_q   <= len_d;
    end
  end

  // effective length: zero acts as one, clamp to what the rod and a tick allow
  logic [CW-1:0] len_ext;
  logic [CW-1:0] n_len;

  assign len_ext = CW'(len_q);

  always_comb begin
    if (len_ext == '0) begin
      n_len = CW'(1);
    end else if (len_ext > CW'(EMIT)) begin
      n_len = CW'(EMIT);
    end else begin
      n_len = len_ext;
    end
  end

  // input item fields
  op_e           op;
  logic [CW-1:0] in_idx;
  temp_t         in_val;
  logic          s_acc;

  assign op     = op_e'(s_axis_tuser);
  assign in_idx = CW'(s_axis_tdata[IDX_W-1:0]);
  assign in_val = s_axis_tdata[IDX_W +: TEMP_W];
  assign s_acc  = s_axis_tvalid && s_axis_tready;

  // control state machine
  state_e state_q, state_d;
  logic   tick_start;
  logic   fill_en;
  logic   set_en;
  logic   tick;
  logic   m_acc;

  always_comb begin
    tick_start = 1'b0;
    fill_en    = 1'b0;
    set_en     = 1'b0;
    if (s_acc) begin
      case (op)
        OP_FILL: fill_en    = 1'b1;
        OP_SET:  set_en     = (in_idx < n_len);
        OP_TICK: tick_start = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (tick_start) begin
        state_d = ST_TICK;
      end
      ST_TICK: if (m_acc && m_axis_tlast) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    tick          = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_TICK: tick          = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sweep: rd_ptr issues reads, ci is the cell being computed
  // window a = old[ci-1], b = old[ci], read data = old[ci+1]
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] ci_q, ci_d;
  logic          rd_vld_q, rd_vld_d;
  logic          have_cur_q, have_cur_d;
  temp_t         a_q, a_d;
  temp_t         b_q, b_d;
  temp_t         rd_data;

  logic          en;
  logic          ci_last;
  logic          fire;
  logic          load;
  logic          consume;
  logic          issue;

  logic          out_vld;
  sten_out_t     out_s;
  logic [CW-1:0] out_idx;
  logic          wb_en;
  logic [CW-1:0] wb_idx;
  temp_t         wb_data;
  sten_in_t      sten_in;

  assign en      = !out_vld || m_axis_tready;
  assign ci_last = (ci_q == n_len - CW'(1));
  assign fire    = tick && have_cur_q && en && (ci_last || rd_vld_q);
  assign load    = tick && rd_vld_q && !have_cur_q;
  assign consume = load || (fire && !ci_last);
  assign issue   = tick && (rd_ptr_q < n_len) && (!rd_vld_q || consume);

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    ci_d       = ci_q;
    rd_vld_d   = rd_vld_q;
    have_cur_d = have_cur_q;
    a_d        = a_q;
    b_d        = b_q;
    if (tick_start) begin
      rd_ptr_d   = '0;
      ci_d       = '0;
      rd_vld_d   = 1'b0;
      have_cur_d = 1'b0;
    end else begin
      if (issue) begin
        rd_ptr_d = rd_ptr_q + CW'(1);
      end
      rd_vld_d = issue || (rd_vld_q && !consume);
      if (load) begin
        have_cur_d = 1'b1;
        b_d        = rd_data;
      end
      if (fire) begin
        ci_d = ci_q + CW'(1);
        a_d  = b_q;
        if (ci_last) begin
          have_cur_d = 1'b0;
        end else begin
          b_d = rd_data;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      ci_q       <= '0;
      rd_vld_q   <= 1'b0;
      have_cur_q <= 1'b0;
    end else begin
      rd_ptr_q   <= rd_ptr_d;
      ci_q       <= ci_d;
      rd_vld_q   <= rd_vld_d;
      have_cur_q <= have_cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  // cell memory: set writes in idle, write-back during a tick
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  temp_t         wr_data;

  assign wr_en   = set_en || wb_en;
  assign wr_addr = set_en ? in_idx[AW-1:0] : wb_idx[AW-1:0];
  assign wr_data = set_en ? in_val : wb_data;

  hrd_cell_mem #(
    .DEPTH (MAX_CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fill_en_i  (fill_en),
    .fill_val_i (in_val),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_en_i    (issue),
    .rd_addr_i  (rd_ptr_q[AW-1:0]),
    .rd_data_o  (rd_data)
  );

  // the last cell sees zero on its right
  assign sten_in.left  = a_q;
  assign sten_in.t     = b_q;
  assign sten_in.right = ci_last ? '0 : rd_data;
  assign sten_in.last  = ci_last;
  assign sten_in.cell0 = (ci_q == '0);

  hrd_stencil #(
    .IW (CW)
  ) u_stencil (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_vld_i  (fire),
    .in_i      (sten_in),
    .in_idx_i  (ci_q),
    .coeff_i   (coeff_q),
    .out_vld_o (out_vld),
    .out_o     (out_s),
    .out_idx_o (out_idx),
    .wb_en_o   (wb_en),
    .wb_idx_o  (wb_idx),
    .wb_data_o (wb_data)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {{TDATA_PAD{1'b0}}, out_s.temp, out_idx[IDX_W-1:0]};
  assign m_axis_tlast  = out_s.last;
  assign m_axis_tuser  = out_s.sat;
  assign m_acc         = m_axis_tvalid && m_axis_tready;

  // results only appear while a tick runs, never beside an open input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("result offered while input is open");

  // the read sweep never runs past the rod
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |-> (rd_ptr_q <= n_len))
    else $error("read pointer beyond rod length");

  // tlast marks exactly the final cell of the rod
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (out_idx == n_len - CW'(1))))
    else $error("last marker on wrong cell");

  // the block is open again right after the final cell leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_acc && m_axis_tlast) |=> s_axis_tready)
    else $error("not idle after final cell");

  // write-back and set never share the write port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_en |-> !set_en)
    else $error("write port conflict");

endmodule
